// ===== rtl/core/rcfs_pkg.sv =====
// Shared types and constants for the RMS-current-from-sums block.
// No dependencies.
package rcfs_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATED_CURRENT = 1'b1;

    localparam logic [15:0] SAMPLE_COUNT_RST  = 16'd64;
    localparam logic [15:0] RATED_CURRENT_RST = 16'd1;

    // final scale is rated_current * 10 / 6875
    localparam int          SCALE_DIV_W = 13;
    localparam logic [SCALE_DIV_W-1:0] SCALE_DIV = 13'd6875;

    // floor(x / 6875) for any x below 2^52 is (x * SCALE_RECIP) >> SCALE_SHIFT
    localparam int          SCALE_SHIFT = 65;
    localparam logic [52:0] SCALE_RECIP =
        53'(((128'd1 << SCALE_SHIFT) / 128'(SCALE_DIV)) + 128'd1);

    // one classified window as it sits in the queue
    typedef struct packed {
        logic [63:0] sum_of_squares;
        logic [31:0] mag;
    } item_t;

endpackage

// ===== rtl/core/rcfs_front.sv =====
// Front end: takes input beats, forms |sum| and parks items in a two-entry queue.
// Depends on rcfs_pkg.
module rcfs_front
    import rcfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        sum_of_squares,
    input  logic signed [31:0] signed_sum,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic [31:0] mag;

    // most negative sum wraps to 2^31, which is the exact magnitude
    assign mag = signed_sum[31] ? ($unsigned(~signed_sum) + 32'd1) : $unsigned(signed_sum);

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].sum_of_squares <= sum_of_squares;
            mem_reg[wr_ptr_reg].mag            <= mag;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !q_pop) |=> count_reg == 2'd2)
        else $error("queue overfilled");

endmodule

// ===== rtl/core/rcfs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
// Divisor must stay constant while items are in flight. Depends on nothing.
module rcfs_div #(
    parameter int W   = 64,
    parameter int DW  = 16,
    parameter int SBW = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [W-1:0]   dividend,
    input  logic [DW-1:0]  divisor,
    input  logic [SBW-1:0] sb_in,
    output logic           out_valid,
    output logic [W-1:0]   quotient,
    output logic [SBW-1:0] sb_out
);

    logic           vld_reg [W];
    logic [DW-1:0]  rem_reg [W];
    logic [W-1:0]   dq_reg  [W];
    logic [SBW-1:0] sb_reg  [W];

    genvar i;
    for (i = 0; i < W; i++)
    begin : g_stage
        logic           vi;
        logic [DW-1:0]  ri;
        logic [W-1:0]   di;
        logic [SBW-1:0] si;
        logic [DW:0]    t;
        logic           ge;

        if (i == 0)
        begin : g_first
            assign vi = in_valid;
            assign ri = '0;
            assign di = dividend;
            assign si = sb_in;
        end
        else
        begin : g_next
            assign vi = vld_reg[i-1];
            assign ri = rem_reg[i-1];
            assign di = dq_reg[i-1];
            assign si = sb_reg[i-1];
        end

        // dividend shifts out the top, quotient bits shift in at the bottom
        assign t  = {ri, di[W-1]};
        assign ge = (t >= {1'b0, divisor});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? DW'(t - {1'b0, divisor}) : t[DW-1:0];
                dq_reg[i]  <= {di[W-2:0], ge};
                sb_reg[i]  <= si;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign quotient  = dq_reg[W-1];
    assign sb_out    = sb_reg[W-1];

endmodule

// ===== rtl/core/rcfs_back.sv =====
// Back end: square, three divides, clamp, square root, scale and saturate.
// Whole pipeline advances together; stalls only when the output beat waits.
// Depends on rcfs_pkg and rcfs_div.
module rcfs_back
    import rcfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] n_eff,
    input  logic [15:0] rated,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] rms_current
);

    logic        en;
    logic        v0_reg;
    logic [63:0] sq_reg;
    logic [63:0] ss_reg;
    logic [63:0] sq_c;

    logic        v1;
    logic [63:0] q1;
    logic [63:0] ss1;
    logic        v2;
    logic [63:0] mean2;
    logic [63:0] q1b;
    logic        v3;
    logic [63:0] offset3;
    logic [63:0] mean3;

    logic        vd_reg;
    logic [63:0] d_reg;

    logic        sv_reg    [32];
    logic [33:0] srem_reg  [32];
    logic [31:0] sroot_reg [32];
    logic [63:0] sval_reg  [32];

    logic        vp_reg;
    logic [47:0] p_reg;
    logic [51:0] x10;

    logic         va_reg;
    logic [52:0]  hh_reg;
    logic [51:0]  hl_reg;
    logic [52:0]  lh_reg;
    logic [51:0]  ll_reg;
    logic         vb_reg;
    logic [52:0]  hh2_reg;
    logic [53:0]  mid_reg;
    logic [51:0]  ll2_reg;
    logic         vc_reg;
    logic [104:0] total;
    logic [39:0]  quo_reg;

    logic        out_valid_reg;
    logic [31:0] rms_reg;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && q_valid;
    assign sq_c  = q_item.mag * q_item.mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_c;
            ss_reg <= q_item.sum_of_squares;
        end
    end

    // floor(m^2 / n^2) is taken as floor(floor(m^2 / n) / n)
    rcfs_div #(.W(64), .DW(16), .SBW(64)) u_div_sq (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v0_reg), .dividend(sq_reg), .divisor(n_eff), .sb_in(ss_reg),
        .out_valid(v1), .quotient(q1), .sb_out(ss1)
    );

    rcfs_div #(.W(64), .DW(16), .SBW(64)) u_div_ss (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1), .dividend(ss1), .divisor(n_eff), .sb_in(q1),
        .out_valid(v2), .quotient(mean2), .sb_out(q1b)
    );

    rcfs_div #(.W(64), .DW(16), .SBW(64)) u_div_off (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2), .dividend(q1b), .divisor(n_eff), .sb_in(mean2),
        .out_valid(v3), .quotient(offset3), .sb_out(mean3)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (en)
            vd_reg <= v3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= (mean3 > offset3) ? (mean3 - offset3) : 64'd0;
    end

    // digit-by-digit square root, two radicand bits per stage
    genvar j;
    for (j = 0; j < 32; j++)
    begin : g_sqrt
        logic        vi;
        logic [33:0] ri;
        logic [31:0] rti;
        logic [63:0] vli;
        logic [35:0] t;
        logic [35:0] trial;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign vi  = vd_reg;
            assign ri  = '0;
            assign rti = '0;
            assign vli = d_reg;
        end
        else
        begin : g_next
            assign vi  = sv_reg[j-1];
            assign ri  = srem_reg[j-1];
            assign rti = sroot_reg[j-1];
            assign vli = sval_reg[j-1];
        end

        assign t     = {ri, vli[63:62]};
        assign trial = {2'b00, rti, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[j] <= 1'b0;
            else if (en)
                sv_reg[j] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[j]  <= ge ? 34'(t - trial) : t[33:0];
                sroot_reg[j] <= {rti[30:0], ge};
                sval_reg[j]  <= {vli[61:0], 2'b00};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= 1'b0;
        else if (en)
            vp_reg <= sv_reg[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= sroot_reg[31] * rated;
    end

    // times 10 as 8x + 2x
    assign x10 = {1'b0, p_reg, 3'b000} + {3'b000, p_reg, 1'b0};

    // divide by 6875 as a reciprocal multiply, split into 26/27-bit partial products
    assign total = {hh2_reg, 52'd0} + {25'd0, mid_reg, 26'd0} + {53'd0, ll2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= vp_reg;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg  <= x10[51:26] * SCALE_RECIP[52:26];
            hl_reg  <= x10[51:26] * SCALE_RECIP[25:0];
            lh_reg  <= x10[25:0] * SCALE_RECIP[52:26];
            ll_reg  <= x10[25:0] * SCALE_RECIP[25:0];
            hh2_reg <= hh_reg;
            mid_reg <= {2'b00, hl_reg} + {1'b0, lh_reg};
            ll2_reg <= ll_reg;
            quo_reg <= total[104:SCALE_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rms_reg <= (|quo_reg[39:32]) ? 32'hFFFF_FFFF : quo_reg[31:0];
    end

    assign out_valid   = out_valid_reg;
    assign rms_current = rms_reg;

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v0_reg) && $stable(vd_reg) && $stable(vp_reg))
        else $error("pipeline moved during stall");

    a_pop_only_en: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> en)
        else $error("queue popped while stalled");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v3 && offset3 >= mean3) |=> d_reg == 64'd0)
        else $error("negative mean square not clamped");

endmodule

// ===== rtl/core/rms_current_from_sums_unit.sv =====
// RMS current from one window's sum and sum of squares: top level.
// Holds the configuration registers. Depends on rcfs_pkg, rcfs_front, rcfs_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries sum_of_squares and signed_sum for
//   one window per beat. Output channel (out_valid/out_ready) returns one
//   rms_current per input beat, in order.
//   cfg_we/cfg_index/cfg_data write sample_count (index 0) or rated_current
//   (index 1); write only while no window is in flight.
// Throughput: one window per cycle, sustained while out_ready stays high.
// Pipeline: three 64-stage bit-serial divider pipelines, a 32-stage
//   square-root pipeline and a three-stage reciprocal multiply for the divide
//   by 6875, plus queue, square, clamp, multiply and output registers.
// Reset: registers return to sample_count = 64, rated_current = 1; queue and
//   pipeline empty.
// Stall: when out_ready is low with a result waiting, the whole back pipeline
//   holds; the two-entry queue keeps taking beats until full, then in_ready
//   drops.
module rms_current_from_sums_unit
    import rcfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           sum_of_squares,
    input  logic signed [31:0]    signed_sum,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           rms_current
);

    logic [15:0] sample_count_reg;
    logic [15:0] rated_current_reg;
    logic [15:0] n_eff;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg  <= SAMPLE_COUNT_RST;
            rated_current_reg <= RATED_CURRENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data;
                REG_RATED_CURRENT: rated_current_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero count acts as one
    assign n_eff = (sample_count_reg == 16'd0) ? 16'd1 : sample_count_reg;

    rcfs_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sum_of_squares(sum_of_squares), .signed_sum(signed_sum),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    rcfs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .n_eff(n_eff), .rated(rated_current_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .out_valid(out_valid), .out_ready(out_ready), .rms_current(rms_current)
    );

endmodule
